FILE: rtl/fcst_pkg.sv
package fcst_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_STANDBY_DUTY = 2'd0;
  localparam logic [1:0] REG_MIN_PWM      = 2'd1;
  localparam logic [1:0] REG_MAX_PWM      = 2'd2;
  localparam logic [1:0] REG_WAIT_SECONDS = 2'd3;

  // register reset values
  localparam logic [6:0]  STANDBY_DUTY_RESET = 7'd25;
  localparam logic [6:0]  MIN_PWM_RESET      = 7'd3;
  localparam logic [7:0]  MAX_PWM_RESET      = 8'd255;
  localparam logic [15:0] WAIT_SECONDS_RESET = 16'd10;

  // drive report code for a drive that is off
  localparam logic [7:0] DRIVE_OFF_CODE = 8'd100;

  // fixed-point reciprocal of 100: floor(m / 100) == (m * RECIP_100) >> RECIP_SHIFT
  // for every m below 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [6:0] DUTY_0   = 7'd0;
  localparam logic [6:0] DUTY_10  = 7'd10;
  localparam logic [6:0] DUTY_20  = 7'd20;
  localparam logic [6:0] DUTY_30  = 7'd30;
  localparam logic [6:0] DUTY_50  = 7'd50;
  localparam logic [6:0] DUTY_75  = 7'd75;
  localparam logic [6:0] DUTY_100 = 7'd100;

  typedef struct packed {
    logic       req_type;
    logic [7:0] report_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pwm_value;
    logic [6:0] duty_percent;
    logic       drive_active;
    logic       in_standby;
  } out_word_t;

  // chosen duty and flags handed to the scaler
  typedef struct packed {
    logic [6:0] duty;
    logic       active;
    logic       standby;
  } duty_word_t;

  // seven-band temperature curve
  function automatic logic [6:0] temp_to_duty(input logic [7:0] t);
    logic [6:0] d;
    case (t) inside
      [8'd0:8'd25]:  d = DUTY_0;
      [8'd26:8'd28]: d = DUTY_10;
      [8'd29:8'd32]: d = DUTY_20;
      [8'd33:8'd35]: d = DUTY_30;
      [8'd36:8'd39]: d = DUTY_50;
      [8'd40:8'd45]: d = DUTY_75;
      default:       d = DUTY_100;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/fcst_scale.sv
module fcst_scale
  import fcst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] min_pwm,
  input  logic [7:0] max_pwm,
  input  logic       in_valid,
  output logic       in_ready,
  input  duty_word_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  // product stage
  logic             s2_valid;
  logic             s2_neg;
  logic [14:0]      s2_mag;
  duty_word_t       s2_word;

  logic             en2;
  logic             en3;
  logic signed [8:0]  span;
  logic signed [16:0] prod;
  logic signed [16:0] prod_abs;

  logic [27:0]        recip;
  logic [8:0]         quot;
  logic signed [10:0] offs;
  logic signed [10:0] level;
  logic [7:0]         pwm_sat;

  assign en3      = !out_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign in_ready = en2;

  assign span     = $signed({1'b0, max_pwm}) - $signed({2'b00, min_pwm});
  assign prod     = $signed({1'b0, in_data.duty}) * span;
  assign prod_abs = prod[16] ? -prod : prod;

  // truncating divide by 100 on the magnitude, sign put back afterwards
  assign recip = s2_mag * RECIP_100;
  assign quot  = recip[27:RECIP_SHIFT];
  assign offs  = s2_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign level = $signed({4'b0000, min_pwm}) + offs;

  always_comb begin
    if (level < 0) begin
      pwm_sat = 8'd0;
    end else if (level > 11'sd255) begin
      pwm_sat = 8'd255;
    end else begin
      pwm_sat = level[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && in_valid) begin
      s2_neg  <= prod[16];
      s2_mag  <= prod_abs[14:0];
      s2_word <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_valid) begin
      out_data.pwm_value    <= pwm_sat;
      out_data.duty_percent <= s2_word.duty;
      out_data.drive_active <= s2_word.active;
      out_data.in_standby   <= s2_word.standby;
    end
  end

endmodule

FILE: rtl/fan_curve_with_standby_timeout_top.sv
// Disk fan drive with a temperature curve and a standby timeout. Each input
// word is either a drive report (req_type 0: 100 means the drive is off, any
// other value is a temperature) or a one-second tick (req_type 1); every word
// yields exactly one result word with the pwm compare value, the chosen duty
// and the drive and standby flags. One word is accepted per clock cycle,
// sustained, as long as results are taken; after its word is accepted, a
// result passes the decision, multiply and output registers in turn. The
// held report, timer and standby flag update in the cycle a
// word is accepted, so back-to-back words see each other's effect. The scale
// min_pwm + duty*(max_pwm-min_pwm)/100 is split over two stages: one signed
// multiply, then a reciprocal multiply for the divide by 100. Configuration
// writes take effect at once and should be made while no word is in flight.
module fan_curve_with_standby_timeout_top
  import fcst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);

  // configuration registers
  logic [6:0]  standby_duty;
  logic [6:0]  min_pwm;
  logic [7:0]  max_pwm;
  logic [15:0] wait_seconds;

  // fan state
  logic [7:0]  held_report;
  logic        standby_flag;
  logic        timer_running;
  logic [15:0] elapsed_seconds;

  logic [7:0]  held_report_next;
  logic        standby_flag_next;
  logic        timer_running_next;
  logic [15:0] elapsed_seconds_next;

  // decision stage
  logic        s1_valid;
  duty_word_t  s1_word;
  duty_word_t  s1_word_next;
  logic        s1_ready;
  logic        accept;
  logic        tick;
  logic        active;

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;
  assign tick     = in_data.req_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      standby_duty <= STANDBY_DUTY_RESET;
      min_pwm      <= MIN_PWM_RESET;
      max_pwm      <= MAX_PWM_RESET;
      wait_seconds <= WAIT_SECONDS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STANDBY_DUTY: standby_duty <= cfg_data[6:0];
        REG_MIN_PWM:      min_pwm      <= cfg_data[6:0];
        REG_MAX_PWM:      max_pwm      <= cfg_data[7:0];
        REG_WAIT_SECONDS: wait_seconds <= cfg_data;
        default:          ;
      endcase
    end
  end

  // a report replaces the held value, a tick re-evaluates it
  assign held_report_next = tick ? held_report : in_data.report_value;
  assign active           = held_report_next != DRIVE_OFF_CODE;

  always_comb begin
    standby_flag_next    = standby_flag;
    timer_running_next   = timer_running;
    elapsed_seconds_next = elapsed_seconds;
    s1_word_next.active  = active;
    if (active) begin
      // drive running: follow the curve, forget any off time
      standby_flag_next    = 1'b0;
      timer_running_next   = 1'b0;
      elapsed_seconds_next = 16'd0;
      s1_word_next.duty    = temp_to_duty(held_report_next);
    end else if (standby_flag) begin
      s1_word_next.duty = min_pwm;
    end else begin
      s1_word_next.duty = standby_duty;
      if (!timer_running) begin
        // first off word starts the count at zero
        timer_running_next   = 1'b1;
        elapsed_seconds_next = 16'd0;
      end else if (tick) begin
        elapsed_seconds_next = elapsed_seconds + 16'd1;
      end
      if (elapsed_seconds_next == wait_seconds) begin
        // timeout word itself shows zero duty
        s1_word_next.duty = DUTY_0;
        standby_flag_next = 1'b1;
      end
    end
    s1_word_next.standby = standby_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_report     <= 8'd0;
      standby_flag    <= 1'b0;
      timer_running   <= 1'b0;
      elapsed_seconds <= 16'd0;
    end else if (accept) begin
      held_report     <= held_report_next;
      standby_flag    <= standby_flag_next;
      timer_running   <= timer_running_next;
      elapsed_seconds <= elapsed_seconds_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= s1_word_next;
    end
  end

  // duty to pwm scaling and the output register
  fcst_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .min_pwm   (min_pwm),
    .max_pwm   (max_pwm),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/fcst_checker.sv
module fcst_checker
  import fcst_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input out_word_t   out_data
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // standby never shows with an active drive
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_active |-> !out_data.in_standby)
    else $error("standby flagged while drive active");

  // an active drive only ever gets a curve duty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_active |->
      out_data.duty_percent == DUTY_0  || out_data.duty_percent == DUTY_10 ||
      out_data.duty_percent == DUTY_20 || out_data.duty_percent == DUTY_30 ||
      out_data.duty_percent == DUTY_50 || out_data.duty_percent == DUTY_75 ||
      out_data.duty_percent == DUTY_100)
    else $error("active duty off the curve");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind fan_curve_with_standby_timeout_top fcst_checker u_checker (.*);

FILE: bench/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcst_pkg::*;

  // request kinds carried in req_type
  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // watchdog: cycles in a row with no word moving on either side
  localparam int STALL_LIMIT = 1000;
  // random words in the main part, spread over the random phases
  localparam int RANDOM_WORDS = 1800;
  localparam int RANDOM_PHASES = 8;
  // ticks pushed through after the wait drops below the running count
  localparam int LATE_TICKS = 40;

  // ---------------------------------------------------------------------
  // fan curve predictor and store of expected result words
  // ---------------------------------------------------------------------
  class fan_scoreboard;
    // register copies
    logic [6:0]  standby_duty;
    logic [6:0]  min_pwm;
    logic [7:0]  max_pwm;
    logic [15:0] wait_seconds;
    // drive state copies
    logic [7:0]  held_report;
    logic        standby_flag;
    logic        timer_running;
    logic [15:0] elapsed;

    out_word_t   expected_q[$];
    int          mismatches;
    int          words_in;
    int          results_checked;
    int          standby_entries;
    int          count_wraps;

    function new();
      standby_duty  = STANDBY_DUTY_RESET;
      min_pwm       = MIN_PWM_RESET;
      max_pwm       = MAX_PWM_RESET;
      wait_seconds  = WAIT_SECONDS_RESET;
      held_report   = '0;
      standby_flag  = 1'b0;
      timer_running = 1'b0;
      elapsed       = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_STANDBY_DUTY: standby_duty = data[6:0];
        REG_MIN_PWM:      min_pwm      = data[6:0];
        REG_MAX_PWM:      max_pwm      = data[7:0];
        REG_WAIT_SECONDS: wait_seconds = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted input word -> one expected result word
    function void note_word(in_word_t w);
      logic [6:0] duty;
      logic       active;
      int         span;
      int         level;
      out_word_t  e;
      words_in++;
      if (w.req_type == REQ_REPORT) held_report = w.report_value;
      active = (held_report != DRIVE_OFF_CODE);
      if (active) begin
        standby_flag  = 1'b0;
        timer_running = 1'b0;
        elapsed       = '0;
        // seven-band temperature curve
        if (held_report <= 8'd25)      duty = DUTY_0;
        else if (held_report <= 8'd28) duty = DUTY_10;
        else if (held_report <= 8'd32) duty = DUTY_20;
        else if (held_report <= 8'd35) duty = DUTY_30;
        else if (held_report <= 8'd39) duty = DUTY_50;
        else if (held_report <= 8'd45) duty = DUTY_75;
        else                           duty = DUTY_100;
      end else if (standby_flag) begin
        duty = min_pwm;
      end else begin
        duty = standby_duty;
        // first off word starts the count, later ticks advance it
        if (!timer_running) begin
          timer_running = 1'b1;
          elapsed       = '0;
        end else if (w.req_type == REQ_TICK) begin
          if (elapsed == 16'hFFFF) count_wraps++;
          elapsed = elapsed + 16'd1;
        end
        if (elapsed == wait_seconds) begin
          duty         = DUTY_0;
          standby_flag = 1'b1;
          standby_entries++;
        end
      end
      // signed scale, truncating toward zero, then clamp to a byte
      span  = int'(max_pwm) - int'(min_pwm);
      level = int'(min_pwm) + (int'(duty) * span) / 100;
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      e.pwm_value    = level[7:0];
      e.duty_percent = duty;
      e.drive_active = active;
      e.in_standby   = standby_flag;
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        mismatches++;
        $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
                 $time, results_checked, name, exp_val, got_val);
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare_field("pwm_value", e.pwm_value, got.pwm_value);
      compare_field("duty_percent", e.duty_percent, got.duty_percent);
      compare_field("drive_active", e.drive_active, got.drive_active);
      compare_field("in_standby", e.in_standby, got.in_standby);
      results_checked++;
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // clock, reset and block under test
  // ---------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;

  always #5ns clk = ~clk;

  fan_curve_with_standby_timeout_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  fan_scoreboard sb;

  // idle draw ceilings; 0 gives a stretch with no idling on that side
  int tx_gap_max = 12;
  int rx_gap_max = 12;
  int settings_used;
  int drains;

  // ---------------------------------------------------------------------
  // driver tasks
  // ---------------------------------------------------------------------

  // present one word, hold it until the block takes it
  task automatic send_word(logic kind, logic [7:0] value);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, report_value: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge
    sb.note_word('{req_type: kind, report_value: value});
  endtask

  // stop sending and wait for every outstanding result word
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    drains++;
  endtask

  // all four registers, only while nothing is in flight
  task automatic configure(logic [6:0] sduty, logic [6:0] lo, logic [7:0] hi,
                           logic [15:0] secs);
    logic [15:0] vals [4];
    vals = '{{9'd0, sduty}, {9'd0, lo}, {8'd0, hi}, secs};
    drain();
    // every word has its result, let the pipe go fully quiet
    repeat (4) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(i[1:0], vals[i]);
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // temperatures mostly around the curve, some anywhere in the byte
  function automatic logic [7:0] pick_temp();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(20, 50));
    return 8'($urandom_range(0, 255));
  endfunction

  // one random episode: mostly on -> off -> timeout -> on, some noise
  task automatic run_episode();
    int k;
    int secs;
    if ($urandom_range(0, 9) < 7) begin
      k = $urandom_range(1, 3);
      repeat (k) begin
        if ($urandom_range(0, 3) == 0) send_word(REQ_TICK, 8'($urandom));
        else send_word(REQ_REPORT, pick_temp());
      end
      send_word(REQ_REPORT, DRIVE_OFF_CODE);
      // ticks around a short wait time so the timeout lands inside the episode
      if (sb.wait_seconds < 16) secs = sb.wait_seconds + $urandom_range(0, 4);
      else secs = $urandom_range(0, 20);
      repeat (secs) begin
        if ($urandom_range(0, 7) == 0) send_word(REQ_REPORT, DRIVE_OFF_CODE);
        else send_word(REQ_TICK, 8'($urandom));
      end
    end else begin
      k = $urandom_range(1, 6);
      repeat (k) begin
        if ($urandom_range(0, 3) == 0) send_word(REQ_REPORT, DRIVE_OFF_CODE);
        else send_word(1'($urandom), 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // result side: random stalls, one check per accepted word
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  // ---------------------------------------------------------------------
  // watchdog on cycles with no word moving
  // ---------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("fan_curve_with_standby_timeout_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin : main_flow
    logic [7:0] band_edges [16] = '{8'd0, 8'd25, 8'd26, 8'd28, 8'd29, 8'd32,
                                    8'd33, 8'd35, 8'd36, 8'd39, 8'd40, 8'd45,
                                    8'd46, 8'd99, 8'd101, 8'd255};
    int target;
    sb        = new();
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: a tick before any report sees held report 0, i.e. active
    send_word(REQ_TICK, 8'hA5);
    // both edges of every temperature band, reset settings
    foreach (band_edges[i]) send_word(REQ_REPORT, band_edges[i]);
    // drive off: first off word starts the count, a repeated off report
    // does not advance it, ticks do
    send_word(REQ_REPORT, DRIVE_OFF_CODE);
    send_word(REQ_TICK, 8'h5A);
    send_word(REQ_REPORT, DRIVE_OFF_CODE);

    // zero wait: the first off word already times out
    configure(7'd30, 7'd5, 8'd200, 16'd0);
    send_word(REQ_REPORT, 8'd40);
    send_word(REQ_REPORT, DRIVE_OFF_CODE);
    send_word(REQ_TICK, 8'hFF);
    send_word(REQ_REPORT, 8'd26);

    // start counting with a long wait, then drop the wait below the count:
    // it is passed over and stays unmet for the rest of this stretch
    tx_gap_max = 0;
    rx_gap_max = 0;
    configure(7'd50, 7'd10, 8'd240, 16'hFFFF);
    send_word(REQ_REPORT, DRIVE_OFF_CODE);
    repeat (3) send_word(REQ_TICK, 8'h00);
    configure(7'd50, 7'd10, 8'd240, 16'd2);
    repeat (LATE_TICKS) send_word(REQ_TICK, 8'($urandom));
    send_word(REQ_REPORT, 8'd30);

    // random phases, the first ones at reset values and register extremes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(STANDBY_DUTY_RESET, MIN_PWM_RESET, MAX_PWM_RESET,
                     WAIT_SECONDS_RESET);
        1: configure(7'd0, 7'd0, 8'd0, 16'd0);
        // falling scale, clamps at zero
        2: configure(7'd127, 7'd127, 8'd0, 16'd1);
        // duty above 100, clamps at 255
        3: configure(7'd127, 7'd0, 8'd255, 16'd3);
        4: configure(7'd100, 7'd100, 8'd255, 16'd2);
        default: begin
          configure(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    8'($urandom_range(0, 255)),
                    ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 12)));
        end
      endcase
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      target = sb.words_in + RANDOM_WORDS / RANDOM_PHASES;
      while (sb.words_in < target) begin
        run_episode();
        // switch idling styles now and then
        if ($urandom_range(0, 5) == 0) tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
        if ($urandom_range(0, 5) == 0) rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
        // sender holds off until the pipe is empty
        if ($urandom_range(0, 30) == 0) drain();
      end
    end

    // wait out everything in flight, then a little more for stray words
    drain();
    repeat (10) @(posedge clk);

    $display("%0d words sent, %0d results checked over %0d register settings",
             sb.words_in, sb.results_checked, settings_used);
    $display("%0d standby entries, %0d count wraps, %0d full drains, %0d mismatches",
             sb.standby_entries, sb.count_wraps, drains, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("fan_curve_with_standby_timeout_top test passed");
    end else begin
      $display("fan_curve_with_standby_timeout_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
